@@ rtl/smoothed_nco_waveform_generator_macros.svh @@
// Assertion macros shared by the oscillator RTL.
// Depends on nothing; the including module provides clk and rst_n.
`ifndef SMOOTHED_NCO_WAVEFORM_GENERATOR_MACROS_SVH
`define SMOOTHED_NCO_WAVEFORM_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define SNCO_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define SNCO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/snco_pkg.sv @@
// Shared types and constants for the smoothed NCO waveform generator.
// No dependencies; imported by every RTL module of the block.
`timescale 1ns / 1ps

package snco_pkg;

  // Waveform codes
  typedef enum logic [1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_SQUARE = 2'd1,
    WAVE_SAW    = 2'd2,
    WAVE_OFF    = 2'd3
  } wave_t;

  // Register indexes (word address)
  localparam logic [1:0] REG_TARGET_STEP  = 2'd0;
  localparam logic [1:0] REG_TARGET_LEVEL = 2'd1;
  localparam logic [1:0] REG_WAVE_SELECT  = 2'd2;
  localparam logic [1:0] REG_MUTE         = 2'd3;

  // Register reset values
  localparam logic [31:0] STEP_RESET  = 32'd97391549;
  localparam logic [15:0] LEVEL_RESET = 16'd6554;
  localparam logic [15:0] LEVEL_FULL  = 16'd32768;

  // Front-to-back queue geometry
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = 2;
  localparam int unsigned Q_CNT_W = 3;

  // Configuration seen by the front end
  typedef struct packed {
    logic [31:0] target_step;
    logic [15:0] target_level;
    wave_t       wave_select;
    logic        mute;
  } cfg_t;

  // One sample job: smoothed step and level plus tick info
  typedef struct packed {
    logic [31:0] step;
    logic [15:0] level;
    wave_t       wave;
    logic        block_end;
  } item_t;

endpackage

@@ rtl/smoothed_nco_waveform_generator.sv @@
// Top level of the smoothed NCO waveform generator.
// Depends on snco_pkg, snco_regs, snco_front, snco_queue and snco_back.
//
// Usage:
//   Input channel (in_valid/in_ready/in_block_end): one transaction is one
//   sample tick; in_block_end marks the last sample of a block and comes back
//   on out_block_end_out. Output channel (out_valid/out_ready/out_sample):
//   one signed 16-bit sample per tick, in tick order.
//   Configuration through the APB-style port at byte addresses 0, 4, 8, 12:
//   target step, target level (Q1.15, capped at 32768), waveform, mute.
//   Write it only while no tick is in flight.
// Timing:
//   Throughput is one sample per clock while out_ready is high. An accepted
//   tick becomes a valid sample via the front glide update into the queue,
//   then phase add, table index, sine ROM read, multiply and output register.
//   The phase add in the back end is the loop that sets the one-per-cycle rate.
// Reset and stalls:
//   rst_n (synchronous, active low) restores the register defaults and clears
//   phase, glides and all valid flags. When out_ready is low with a valid
//   sample waiting the back end holds; the four-entry queue keeps taking
//   ticks until full, then in_ready drops.
`timescale 1ns / 1ps

module smoothed_nco_waveform_generator #(
  parameter int unsigned GLIDE_SHIFT      = 12,
  parameter int unsigned SINE_TABLE_DEPTH = 1024,
  parameter int unsigned PHASE_BITS       = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_block_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_sample,
  output logic               out_block_end_out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import snco_pkg::*;

  cfg_t  cfg;
  item_t push_item;
  item_t pop_item;
  logic  q_push, q_full, q_pop, q_empty;

  // configuration registers
  snco_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // tick intake and glides
  snco_front #(
    .GLIDE_SHIFT (GLIDE_SHIFT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_block_end (in_block_end),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (push_item)
  );

  // decoupling queue
  snco_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  // waveform synthesis
  snco_back #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .PHASE_BITS       (PHASE_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_item            (pop_item),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sample        (out_sample),
    .out_block_end_out (out_block_end_out)
  );

endmodule

@@ rtl/snco_regs.sv @@
// APB-style configuration registers of the smoothed NCO.
// Depends on snco_pkg (cfg_t, register indexes, reset values).
`timescale 1ns / 1ps

module snco_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output snco_pkg::cfg_t      cfg
);
  import snco_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;
  logic [15:0] level_wr;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  // levels above full scale are stored as full scale
  assign level_wr = (pwdata[15:0] > LEVEL_FULL) ? LEVEL_FULL : pwdata[15:0];

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_step  <= STEP_RESET;
      cfg_r.target_level <= LEVEL_RESET;
      cfg_r.wave_select  <= WAVE_SINE;
      cfg_r.mute         <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TARGET_STEP:  cfg_r.target_step  <= pwdata;
        REG_TARGET_LEVEL: cfg_r.target_level <= level_wr;
        REG_WAVE_SELECT:  cfg_r.wave_select  <= wave_t'(pwdata[1:0]);
        REG_MUTE:         cfg_r.mute         <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      REG_TARGET_STEP:  prdata = cfg_r.target_step;
      REG_TARGET_LEVEL: prdata = {16'd0, cfg_r.target_level};
      REG_WAVE_SELECT:  prdata = {30'd0, cfg_r.wave_select};
      REG_MUTE:         prdata = {31'd0, cfg_r.mute};
      default:          prdata = 32'd0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/snco_front.sv @@
// Front end: accepts sample ticks and advances the step and level glides.
// Depends on snco_pkg (cfg_t, item_t) and the assertion macro header.
`timescale 1ns / 1ps

module snco_front #(
  parameter int unsigned GLIDE_SHIFT = 12
) (
  input  logic            clk,
  input  logic            rst_n,
  input  snco_pkg::cfg_t  cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_block_end,
  input  logic            q_full,
  output logic            q_push,
  output snco_pkg::item_t q_item
);
  import snco_pkg::*;
  `include "smoothed_nco_waveform_generator_macros.svh"

  localparam int unsigned StepW  = 32 + GLIDE_SHIFT;
  localparam int unsigned LevelW = 16 + GLIDE_SHIFT;

  logic [StepW-1:0]         glide_step_r, glide_step_nxt;
  logic [LevelW-1:0]        glide_level_r, glide_level_nxt;
  logic                     started_r;
  logic                     fire;
  logic [StepW-1:0]         step_tgt, step_cur;
  logic signed [StepW:0]    step_diff, step_adj;
  logic [LevelW-1:0]        level_tgt;
  logic signed [LevelW:0]   level_diff, level_adj;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;

  // step glide; the first tick after reset jumps straight to the target
  always_comb begin
    step_tgt       = StepW'(cfg.target_step) << GLIDE_SHIFT;
    step_cur       = started_r ? glide_step_r : step_tgt;
    step_diff      = $signed({1'b0, step_tgt}) - $signed({1'b0, step_cur});
    step_adj       = step_diff >>> GLIDE_SHIFT;
    glide_step_nxt = step_cur + step_adj[StepW-1:0];
  end

  // level glide, toward zero while muted
  always_comb begin
    level_tgt       = cfg.mute ? '0 : (LevelW'(cfg.target_level) << GLIDE_SHIFT);
    level_diff      = $signed({1'b0, level_tgt}) - $signed({1'b0, glide_level_r});
    level_adj       = level_diff >>> GLIDE_SHIFT;
    glide_level_nxt = glide_level_r + level_adj[LevelW-1:0];
  end

  // glide state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glide_step_r  <= '0;
      glide_level_r <= '0;
      started_r     <= 1'b0;
    end else if (fire) begin
      glide_step_r  <= glide_step_nxt;
      glide_level_r <= glide_level_nxt;
      started_r     <= 1'b1;
    end
  end

  // job handed to the back end
  assign q_push          = fire;
  assign q_item.step     = glide_step_nxt[StepW-1:GLIDE_SHIFT];
  assign q_item.level    = glide_level_nxt[LevelW-1:GLIDE_SHIFT];
  assign q_item.wave     = cfg.wave_select;
  assign q_item.block_end = in_block_end;

  `SNCO_ASSERT_NEXT(a_started_after_tick, fire, started_r, "glide not marked started")
  `SNCO_ASSERT_IMPLY(a_no_push_when_full, q_full, !q_push, "front pushed into full queue")
  `SNCO_ASSERT_IMPLY(a_level_in_range, 1'b1, glide_level_r <= (LevelW'(LEVEL_FULL) << GLIDE_SHIFT),
                     "level glide above full scale")

endmodule

@@ rtl/snco_queue.sv @@
// Short FIFO between the front end and the back end.
// Depends on snco_pkg (item_t, queue geometry) and the assertion macro header.
`timescale 1ns / 1ps

module snco_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  snco_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output snco_pkg::item_t pop_item,
  output logic            empty
);
  import snco_pkg::*;
  `include "smoothed_nco_waveform_generator_macros.svh"

  item_t              mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r, count_nxt;
  logic               do_push, do_pop;

  assign full     = (count_r == Q_CNT_W'(Q_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_item;
  end

  `SNCO_ASSERT_IMPLY(a_count_bound, 1'b1, count_r <= Q_CNT_W'(Q_DEPTH), "queue overfilled")
  `SNCO_ASSERT_NEXT(a_push_counts, do_push && !do_pop, !empty, "queue empty after push")
  `SNCO_ASSERT_NEXT(a_pop_counts, do_pop && !do_push, !full, "queue full after pop")

endmodule

@@ rtl/snco_back.sv @@
// Back end: phase accumulator, quarter-wave sine ROM, level scaling, output register.
// Depends on snco_pkg (item_t, wave_t) and the assertion macro header.
`timescale 1ns / 1ps

module snco_back #(
  parameter int unsigned SINE_TABLE_DEPTH = 1024,
  parameter int unsigned PHASE_BITS       = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  snco_pkg::item_t    q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_sample,
  output logic               out_block_end_out
);
  import snco_pkg::*;
  `include "smoothed_nco_waveform_generator_macros.svh"

  localparam int unsigned IdxW     = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned ScaleW   = 30 + IdxW;
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  typedef logic [14:0] sine_rom_t [0:SINE_TABLE_DEPTH];

  // one Taylor step: t * x^2 in Q30
  function automatic logic [63:0] taylor_mul(input logic [63:0] t, input logic [63:0] x);
    logic [63:0] p;
    p = (t * x) >> 30;
    return (p * x) >> 30;
  endfunction

  // quarter-wave sine table in Q15, built at elaboration
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t          rom;
    logic [63:0]        x;
    logic [63:0]        t;
    logic signed [63:0] sum;
    logic [63:0]        q;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      x   = (HalfPiQ30 * 64'(i)) / 64'(SINE_TABLE_DEPTH);
      t   = x;
      sum = $signed(x);
      t = taylor_mul(t, x) / 64'd6;   sum = sum - $signed(t);
      t = taylor_mul(t, x) / 64'd20;  sum = sum + $signed(t);
      t = taylor_mul(t, x) / 64'd42;  sum = sum - $signed(t);
      t = taylor_mul(t, x) / 64'd72;  sum = sum + $signed(t);
      t = taylor_mul(t, x) / 64'd110; sum = sum - $signed(t);
      t = taylor_mul(t, x) / 64'd156; sum = sum + $signed(t);
      t = taylor_mul(t, x) / 64'd210; sum = sum - $signed(t);
      if (sum < 0) sum = 0;
      if (sum > 64'sd1073741824) sum = 64'sd1073741824;
      q = ($unsigned(sum) * 64'd32767 + 64'd536870912) >> 30;
      rom[i] = q[14:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SineRom = build_sine_rom();

  // pipeline control: every stage moves together unless the output stalls
  logic advance;

  // stage 1: phase
  logic [PHASE_BITS-1:0] phase_acc_r, phase_acc_nxt;
  logic                  s1_v_r;
  logic [31:0]           s1_u_r;
  logic [15:0]           s1_lvl_r;
  wave_t                 s1_wave_r;
  logic                  s1_be_r;

  // stage 2: table index
  logic                  s2_v_r;
  logic [IdxW-1:0]       s2_idx_r, s2_idx_nxt;
  logic [ScaleW-1:0]     s2_scaled;
  logic [IdxW-1:0]       s2_n;
  logic [31:0]           s2_p_r;
  logic [15:0]           s2_lvl_r;
  wave_t                 s2_wave_r;
  logic                  s2_be_r;

  // stage 3: ROM read
  logic                  s3_v_r;
  logic [14:0]           s3_rom_r;
  logic [31:0]           s3_p_r;
  logic [15:0]           s3_lvl_r;
  wave_t                 s3_wave_r;
  logic                  s3_be_r;

  // stage 4: multiply
  logic                  s4_v_r;
  logic signed [32:0]    mul_a;
  logic signed [16:0]    mul_b;
  logic signed [49:0]    s4_prod_r, s4_prod_nxt;
  logic [15:0]           s4_sq_r, s4_sq_nxt;
  logic                  s4_neg_r;
  wave_t                 s4_wave_r;
  logic                  s4_be_r;

  // output register
  logic                  out_valid_r;
  logic [15:0]           out_sample_r, out_sample_nxt;
  logic                  out_be_r;
  logic [15:0]           sine_mag;

  assign advance = !out_valid_r || out_ready;
  assign q_pop   = advance && !q_empty;

  // stage 1: accumulate the phase, left-align it to 32 bits
  assign phase_acc_nxt = phase_acc_r + q_item.step[PHASE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r <= '0;
      s1_v_r      <= 1'b0;
    end else if (advance) begin
      s1_v_r <= q_pop;
      if (q_pop) phase_acc_r <= phase_acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_u_r    <= 32'(phase_acc_nxt) << (32 - PHASE_BITS);
      s1_lvl_r  <= q_item.level;
      s1_wave_r <= q_item.wave;
      s1_be_r   <= q_item.block_end;
    end
  end

  // stage 2: quadrant fold into a table index
  always_comb begin
    s2_scaled  = ScaleW'(s1_u_r[29:0]) * ScaleW'(SINE_TABLE_DEPTH);
    s2_n       = s2_scaled[ScaleW-1:30];
    s2_idx_nxt = s1_u_r[30] ? (IdxW'(SINE_TABLE_DEPTH) - s2_n) : s2_n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (advance) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_idx_r  <= s2_idx_nxt;
      s2_p_r    <= s1_u_r;
      s2_lvl_r  <= s1_lvl_r;
      s2_wave_r <= s1_wave_r;
      s2_be_r   <= s1_be_r;
    end
  end

  // stage 3: registered sine ROM read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (advance) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_rom_r  <= SineRom[s2_idx_r];
      s3_p_r    <= s2_p_r;
      s3_lvl_r  <= s2_lvl_r;
      s3_wave_r <= s2_wave_r;
      s3_be_r   <= s2_be_r;
    end
  end

  // stage 4: one shared multiplier (table entry or phase times level), square in parallel
  always_comb begin
    mul_a       = (s3_wave_r == WAVE_SINE) ? $signed({18'd0, s3_rom_r})
                                           : $signed({s3_p_r[31], s3_p_r});
    mul_b       = $signed({1'b0, s3_lvl_r});
    s4_prod_nxt = mul_a * mul_b;
    // positive phase gives +level (saturated), otherwise -level
    if (!s3_p_r[31] && (s3_p_r != '0)) begin
      s4_sq_nxt = s3_lvl_r[15] ? 16'h7FFF : s3_lvl_r;
    end else begin
      s4_sq_nxt = 16'(~s3_lvl_r + 16'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (advance) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s4_prod_r <= s4_prod_nxt;
      s4_sq_r   <= s4_sq_nxt;
      s4_neg_r  <= s3_p_r[31];
      s4_wave_r <= s3_wave_r;
      s4_be_r   <= s3_be_r;
    end
  end

  // output select
  assign sine_mag = s4_prod_r[30:15];

  always_comb begin
    case (s4_wave_r)
      WAVE_SINE:   out_sample_nxt = s4_neg_r ? 16'(~sine_mag + 16'd1) : sine_mag;
      WAVE_SQUARE: out_sample_nxt = s4_sq_r;
      WAVE_SAW:    out_sample_nxt = s4_prod_r[46:31];
      default:     out_sample_nxt = 16'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_sample_r <= out_sample_nxt;
      out_be_r     <= s4_be_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sample        = $signed(out_sample_r);
  assign out_block_end_out = out_be_r;

  `SNCO_ASSERT_NEXT(a_s4_to_out, advance && s4_v_r, out_valid_r, "sample lost at output stage")
  `SNCO_ASSERT_NEXT(a_stall_holds_s4, !advance && s4_v_r, s4_v_r && $stable(s4_prod_r),
                    "stage 4 changed during stall")
  `SNCO_ASSERT_IMPLY(a_pop_only_on_advance, q_pop, advance && !q_empty, "pop while stalled")

endmodule
